// ===== rtl/core/sed_pkg.sv =====
`default_nettype none

package sed_pkg;

    // Largest number of bytes one input item can produce (a supplementary code point).
    localparam int SED_MAX_BYTES = 4;

    // Default depth of the queue between the decoder and the result serializer.
    localparam int SED_QUEUE_DEPTH = 4;

    // One decoded input item: its output bytes in order, how many there are,
    // and the end-of-string verdict when the item closes the string.
    typedef struct packed {
        logic [SED_MAX_BYTES-1:0][7:0] bytes;
        logic [2:0]                    count;
        logic                          last;
        logic                          ok;
    } t_entry;

endpackage

`default_nettype wire

// ===== rtl/core/string_escape_decoder.sv =====
// Flow: an accepted item is written into the queue, then walked into the output
// register. Throughput: one input item per cycle while the queue has room; one result
// beat per cycle on the output while i_ready is high, so an item that expands to n
// bytes holds the serializer for n beats.
// Reset: i_rst_n is synchronous and active low; it clears the decoder state, empties
// the queue and drops any pending result. No clearing pass follows reset.
`default_nettype none

module string_escape_decoder #(
    parameter int QUEUE_DEPTH = sed_pkg::SED_QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_last_in,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_byte_valid,
    output logic             o_run_last,
    output logic             o_string_done,
    output logic             o_string_ok
);
    import sed_pkg::*;

    // The front end decodes escapes and runs the UTF-8 check, producing one queue
    // entry per item that yields bytes or ends the string. Items that yield nothing
    // and do not end the string leave no trace in the queue.
    logic   w_push;
    t_entry w_push_entry;
    logic   w_room;

    // The back end walks the head entry one byte per beat into the output register.
    logic   w_head_valid;
    t_entry w_head;
    logic   w_pop;

    sed_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in_byte  (i_in_byte),
        .i_has_byte (i_has_byte),
        .i_last_in  (i_last_in),
        .i_room     (w_room),
        .o_push     (w_push),
        .o_entry    (w_push_entry)
    );

    sed_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_room  (w_room),
        .o_valid (w_head_valid),
        .o_entry (w_head),
        .i_pop   (w_pop)
    );

    sed_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (w_head_valid),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_run_last    (o_run_last),
        .o_string_done (o_string_done),
        .o_string_ok   (o_string_ok)
    );

    // Every item that closes a string must reach the queue.
    a_last_pushed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_last_in |-> w_push)
        else $error("end of string was not queued");

    // A pass verdict only travels on the closing beat of a string.
    a_ok_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_string_ok |-> o_string_done && o_run_last)
        else $error("string_ok without string_done");

    // A beat without a byte exists only to close an empty-output item.
    a_empty_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_byte_valid |-> o_string_done && (o_out_byte == 8'd0))
        else $error("empty beat that does not end the string");

    // The serializer only takes entries that the queue holds.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head_valid)
        else $error("pop from an empty queue");

endmodule

`default_nettype wire

// ===== rtl/core/sed_front.sv =====
`default_nettype none

module sed_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [7:0]      i_in_byte,
    input  wire logic            i_has_byte,
    input  wire logic            i_last_in,
    input  wire logic            i_room,
    output logic                 o_push,
    output sed_pkg::t_entry      o_entry
);
    import sed_pkg::*;

    typedef enum logic [2:0] {
        PH_PLAIN  = 3'd0,
        PH_ESCAPE = 3'd1,
        PH_HEX_HI = 3'd2,
        PH_BSL_LO = 3'd3,
        PH_U_LO   = 3'd4,
        PH_HEX_LO = 3'd5
    } t_phase;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    t_phase      r_phase,   n_phase;
    logic [1:0]  r_digits,  n_digits;
    logic [15:0] r_high,    n_high;
    logic [15:0] r_low,     n_low;
    logic        r_failed,  n_failed;
    logic [1:0]  r_pending, n_pending;
    logic [20:0] r_code,    n_code;
    logic [1:0]  r_class,   n_class;

    logic        w_accept;
    logic [4:0]  w_hex;
    logic [15:0] w_unit_hi;
    logic [15:0] w_unit_lo;
    logic [20:0] w_pair;
    logic [20:0] w_min;
    t_entry      w_entry;

    // Returns {digit ok, digit value}.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] res;
        res = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            res = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            res = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            res = {1'b1, 4'(c - 8'h37)};
        end
        return res;
    endfunction

    function automatic t_entry encode(input logic [20:0] code);
        t_entry e;
        e = '0;
        if (code <= 21'h00007F) begin
            e.bytes[0] = code[7:0];
            e.count    = 3'd1;
        end else if (code <= 21'h0007FF) begin
            e.bytes[0] = {3'b110, code[10:6]};
            e.bytes[1] = {2'b10, code[5:0]};
            e.count    = 3'd2;
        end else if (code <= 21'h00FFFF) begin
            e.bytes[0] = {4'b1110, code[15:12]};
            e.bytes[1] = {2'b10, code[11:6]};
            e.bytes[2] = {2'b10, code[5:0]};
            e.count    = 3'd3;
        end else begin
            e.bytes[0] = {5'b11110, code[20:18]};
            e.bytes[1] = {2'b10, code[17:12]};
            e.bytes[2] = {2'b10, code[11:6]};
            e.bytes[3] = {2'b10, code[5:0]};
            e.count    = 3'd4;
        end
        return e;
    endfunction

    assign w_accept  = i_valid && i_room;
    assign o_ready   = i_room;
    assign w_hex     = hex_value(i_in_byte);
    assign w_unit_hi = {r_high[11:0], w_hex[3:0]};
    assign w_unit_lo = {r_low[11:0], w_hex[3:0]};
    assign w_pair    = 21'h010000 + {1'b0, r_high[9:0], w_unit_lo[9:0]};
    assign n_code    = (r_pending == 2'd0) ? 21'd0 : {r_code[14:0], i_in_byte[5:0]};

    always_comb begin
        case (r_class)
            2'd1:    w_min = 21'h000080;
            2'd2:    w_min = 21'h000800;
            default: w_min = 21'h010000;
        endcase
    end

    always_comb begin
        n_phase   = r_phase;
        n_digits  = r_digits;
        n_high    = r_high;
        n_low     = r_low;
        n_failed  = r_failed;
        n_pending = r_pending;
        n_class   = r_class;
        w_entry   = '0;

        if (w_accept && i_has_byte && !r_failed) begin
            unique case (r_phase)
                PH_PLAIN: begin
                    if (i_in_byte == CH_BACKSLASH) begin
                        n_phase = PH_ESCAPE;
                    end else if (i_in_byte < CH_SPACE) begin
                        n_failed = 1'b1;
                    end else begin
                        w_entry.bytes[0] = i_in_byte;
                        w_entry.count    = 3'd1;
                        // Raw bytes are the only ones that can form a multi-byte
                        // sequence, so only they run the full UTF-8 check.
                        if (r_pending == 2'd0) begin
                            if (i_in_byte[7]) begin
                                if (i_in_byte[7:5] == 3'b110) begin
                                    n_pending = 2'd1;
                                    n_class   = 2'd1;
                                end else if (i_in_byte[7:4] == 4'b1110) begin
                                    n_pending = 2'd2;
                                    n_class   = 2'd2;
                                end else if (i_in_byte[7:3] == 5'b11110) begin
                                    n_pending = 2'd3;
                                    n_class   = 2'd3;
                                end else begin
                                    n_failed = 1'b1;
                                end
                            end
                        end else if (i_in_byte[7:6] != 2'b10) begin
                            n_failed = 1'b1;
                        end else begin
                            n_pending = r_pending - 2'd1;
                            if (r_pending == 2'd1) begin
                                if (n_code < w_min || n_code > 21'h10FFFF ||
                                    (n_code >= 21'h00D800 && n_code <= 21'h00DFFF)) begin
                                    n_failed = 1'b1;
                                end
                            end
                        end
                    end
                end
                PH_ESCAPE: begin
                    n_phase = PH_PLAIN;
                    if (i_in_byte == CH_QUOTE || i_in_byte == CH_BACKSLASH) begin
                        w_entry.bytes[0] = i_in_byte;
                        w_entry.count    = 3'd1;
                    end else if (i_in_byte == CH_N) begin
                        w_entry.bytes[0] = CH_LF;
                        w_entry.count    = 3'd1;
                    end else if (i_in_byte == CH_R) begin
                        w_entry.bytes[0] = CH_CR;
                        w_entry.count    = 3'd1;
                    end else if (i_in_byte == CH_T) begin
                        w_entry.bytes[0] = CH_TAB;
                        w_entry.count    = 3'd1;
                    end else if (i_in_byte == CH_U) begin
                        n_phase  = PH_HEX_HI;
                        n_digits = 2'd0;
                        n_high   = 16'd0;
                    end else begin
                        n_failed = 1'b1;
                    end
                    // A decoded character never continues an open sequence.
                    if (w_entry.count != 3'd0 && r_pending != 2'd0) begin
                        n_failed = 1'b1;
                    end
                end
                PH_HEX_HI: begin
                    if (!w_hex[4]) begin
                        n_failed = 1'b1;
                    end else begin
                        n_high = w_unit_hi;
                        if (r_digits != 2'd3) begin
                            n_digits = r_digits + 2'd1;
                        end else begin
                            n_digits = 2'd0;
                            if (w_unit_hi >= 16'hD800 && w_unit_hi <= 16'hDBFF) begin
                                n_phase = PH_BSL_LO;
                            end else if (w_unit_hi >= 16'hDC00 && w_unit_hi <= 16'hDFFF) begin
                                n_failed = 1'b1;
                            end else begin
                                n_phase = PH_PLAIN;
                                w_entry = encode({5'd0, w_unit_hi});
                                if (r_pending != 2'd0) begin
                                    n_failed = 1'b1;
                                end
                            end
                        end
                    end
                end
                PH_BSL_LO: begin
                    if (i_in_byte == CH_BACKSLASH) begin
                        n_phase = PH_U_LO;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                PH_U_LO: begin
                    if (i_in_byte == CH_U) begin
                        n_phase  = PH_HEX_LO;
                        n_digits = 2'd0;
                        n_low    = 16'd0;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                PH_HEX_LO: begin
                    if (!w_hex[4]) begin
                        n_failed = 1'b1;
                    end else begin
                        n_low = w_unit_lo;
                        if (r_digits != 2'd3) begin
                            n_digits = r_digits + 2'd1;
                        end else begin
                            n_digits = 2'd0;
                            if (w_unit_lo < 16'hDC00 || w_unit_lo > 16'hDFFF) begin
                                n_failed = 1'b1;
                            end else begin
                                n_phase = PH_PLAIN;
                                w_entry = encode(w_pair);
                                if (r_pending != 2'd0) begin
                                    n_failed = 1'b1;
                                end
                            end
                        end
                    end
                end
                default: begin
                    n_failed = 1'b1;
                end
            endcase
        end

        if (w_accept && i_last_in) begin
            w_entry.last = 1'b1;
            w_entry.ok   = !n_failed && (n_phase == PH_PLAIN) && (n_pending == 2'd0);
            n_phase   = PH_PLAIN;
            n_digits  = 2'd0;
            n_high    = 16'd0;
            n_low     = 16'd0;
            n_failed  = 1'b0;
            n_pending = 2'd0;
            n_class   = 2'd0;
        end
    end

    assign o_push  = w_accept && (w_entry.count != 3'd0 || i_last_in);
    assign o_entry = w_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_PLAIN;
            r_digits  <= 2'd0;
            r_high    <= 16'd0;
            r_low     <= 16'd0;
            r_failed  <= 1'b0;
            r_pending <= 2'd0;
            r_code    <= 21'd0;
            r_class   <= 2'd0;
        end else begin
            r_phase   <= n_phase;
            r_digits  <= n_digits;
            r_high    <= n_high;
            r_low     <= n_low;
            r_failed  <= n_failed;
            r_pending <= n_pending;
            r_class   <= n_class;
            if (w_accept && i_last_in) begin
                r_code <= 21'd0;
            end else if (w_accept && i_has_byte && !r_failed && r_phase == PH_PLAIN &&
                         i_in_byte >= CH_SPACE && i_in_byte != CH_BACKSLASH) begin
                if (r_pending == 2'd0) begin
                    // The payload bits of a lead byte depend on the sequence length.
                    if (i_in_byte[7:5] == 3'b110) begin
                        r_code <= {16'd0, i_in_byte[4:0]};
                    end else if (i_in_byte[7:4] == 4'b1110) begin
                        r_code <= {17'd0, i_in_byte[3:0]};
                    end else begin
                        r_code <= {18'd0, i_in_byte[2:0]};
                    end
                end else if (i_in_byte[7:6] == 2'b10) begin
                    r_code <= n_code;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sed_queue.sv =====
`default_nettype none

module sed_queue #(
    parameter int DEPTH = sed_pkg::SED_QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire sed_pkg::t_entry  i_entry,
    output logic                  o_room,
    output logic                  o_valid,
    output sed_pkg::t_entry       o_entry,
    input  wire logic             i_pop
);
    import sed_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_slots [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_push;
    logic               w_pop;

    assign o_room  = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_slots[r_rd_ptr];
    assign w_push  = i_push && o_room;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slots[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sed_back.sv =====
`default_nettype none

module sed_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_head_valid,
    input  wire sed_pkg::t_entry  i_head,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [7:0]            o_out_byte,
    output logic                  o_byte_valid,
    output logic                  o_run_last,
    output logic                  o_string_done,
    output logic                  o_string_ok
);
    import sed_pkg::*;

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_byte_valid;
    logic       r_run_last;
    logic       r_done;
    logic       r_ok;
    logic       w_step;
    logic       w_end;
    logic       w_has;

    assign w_has  = (i_head.count != 3'd0);
    assign w_end  = !w_has || ({1'b0, r_idx} == i_head.count - 3'd1);
    assign w_step = i_head_valid && (!r_valid || i_ready);
    assign o_pop  = w_step && w_end;

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_byte       <= w_has ? i_head.bytes[r_idx] : 8'd0;
            r_byte_valid <= w_has;
            r_run_last   <= w_end;
            r_done       <= w_end && i_head.last;
            r_ok         <= w_end && i_head.last && i_head.ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (w_step) begin
                r_idx <= w_end ? 2'd0 : r_idx + 2'd1;
            end
            if (w_step) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_out_byte    = r_byte;
    assign o_byte_valid  = r_byte_valid;
    assign o_run_last    = r_run_last;
    assign o_string_done = r_done;
    assign o_string_ok   = r_ok;

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the string escape decoder.
module tb_top;

    // Most result beats one input beat can cause.
    localparam int MAX_BEATS = sed_pkg::SED_MAX_BYTES;

    // Random input beats that carry a byte or close a string.
    localparam int RANDOM_ITEMS = 420;

    // Cycles to keep watching the output once nothing more is due.
    localparam int DRAIN_CYCLES = 20;

    // Hard stop, well beyond the slowest legal run.
    localparam longint WATCHDOG_NS = 64'd10_000_000;

    // Characters with a meaning to the escape decoder.
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // UTF-16 surrogate ranges and the Unicode ceiling.
    localparam logic [15:0] HIGH_SURR_LO = 16'hD800;
    localparam logic [15:0] HIGH_SURR_HI = 16'hDBFF;
    localparam logic [15:0] LOW_SURR_LO  = 16'hDC00;
    localparam logic [15:0] LOW_SURR_HI  = 16'hDFFF;
    localparam logic [20:0] CODE_MAX     = 21'h10FFFF;

    // Where the decoder stands inside an escape sequence.
    typedef enum logic [2:0] {
        PH_PLAIN,
        PH_ESCAPE,
        PH_HIGH_HEX,
        PH_LOW_BSLASH,
        PH_LOW_U,
        PH_LOW_HEX
    } t_phase;

    // One result beat as the block presents it.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       string_done;
        logic       string_ok;
    } t_beat;

    // One input beat. When typed is set, the single result beat it causes is written
    // into the row itself (it always closes the string) instead of being predicted.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       has_byte;
        logic       last_in;
        logic       typed;
        logic [7:0] exp_byte;
        logic       exp_bvalid;
        logic       exp_ok;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_in_byte;
    logic       i_has_byte;
    logic       i_last_in;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_out_byte;
    logic       o_byte_valid;
    logic       o_run_last;
    logic       o_string_done;
    logic       o_string_ok;

    string_escape_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_in_byte     (i_in_byte),
        .i_has_byte    (i_has_byte),
        .i_last_in     (i_last_in),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_run_last    (o_run_last),
        .o_string_done (o_string_done),
        .o_string_ok   (o_string_ok)
    );

    // Result beats that the block still owes, oldest first.
    t_beat due_beats[$];
    int    mismatch_cnt = 0;

    // Input beats of the string being built by the random generator.
    t_row  str_q[$];

    // Decoder state, kept in step with the block one accepted beat at a time.
    t_phase      ph;
    logic [1:0]  digits;
    logic [15:0] hi_unit;
    logic [15:0] lo_unit;
    logic        failed;
    logic [1:0]  cont_owed;
    logic [20:0] seq_code;
    logic [1:0]  seq_class;

    // Bytes produced by the current input beat, and the beats they turn into.
    logic [7:0] emit_buf [MAX_BEATS];
    int         emit_cnt;
    t_beat      pred_beats [MAX_BEATS];
    int         pred_n;

    t_row dir_rows [24];

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        #(WATCHDOG_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 8'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 8'h41 + 10;
        return -1;
    endfunction

    // Plain UTF-8 encoding of a code point. Code points above 0xFFFF always take
    // four bytes, keeping only three bits in the lead byte.
    function automatic void utf8_bytes(input logic [20:0] cp, output logic [3:0][7:0] b,
                                       output int n);
        b = '0;
        if (cp <= 21'h7F) begin
            b[0] = cp[7:0];
            n = 1;
        end else if (cp <= 21'h7FF) begin
            b[0] = {3'b110, cp[10:6]};
            b[1] = {2'b10, cp[5:0]};
            n = 2;
        end else if (cp <= 21'hFFFF) begin
            b[0] = {4'b1110, cp[15:12]};
            b[1] = {2'b10, cp[11:6]};
            b[2] = {2'b10, cp[5:0]};
            n = 3;
        end else begin
            b[0] = {5'b11110, cp[20:18]};
            b[1] = {2'b10, cp[17:12]};
            b[2] = {2'b10, cp[11:6]};
            b[3] = {2'b10, cp[5:0]};
            n = 4;
        end
    endfunction

    function automatic void clear_state();
        ph        = PH_PLAIN;
        digits    = '0;
        hi_unit   = '0;
        lo_unit   = '0;
        failed    = 1'b0;
        cont_owed = '0;
        seq_code  = '0;
        seq_class = '0;
    endfunction

    // Runs one delivered byte through the UTF-8 stream check.
    function automatic void check_utf8(input logic [7:0] b);
        logic [20:0] floor_cp;
        if (cont_owed == 2'd0) begin
            if (b[7:5] == 3'b110) begin
                cont_owed = 2'd1;
                seq_code  = {16'b0, b[4:0]};
                seq_class = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                cont_owed = 2'd2;
                seq_code  = {17'b0, b[3:0]};
                seq_class = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
                cont_owed = 2'd3;
                seq_code  = {18'b0, b[2:0]};
                seq_class = 2'd3;
            end else if (b[7]) begin
                failed = 1'b1;
            end
        end else if (b[7:6] != 2'b10) begin
            failed = 1'b1;
        end else begin
            seq_code  = {seq_code[14:0], b[5:0]};
            cont_owed = cont_owed - 2'd1;
            if (cont_owed == 2'd0) begin
                // The shortest form sets the floor for each sequence length.
                floor_cp = (seq_class == 2'd1) ? 21'h80 :
                           (seq_class == 2'd2) ? 21'h800 : 21'h10000;
                if (seq_code < floor_cp || seq_code > CODE_MAX ||
                    (seq_code >= 21'(HIGH_SURR_LO) && seq_code <= 21'(LOW_SURR_HI)))
                    failed = 1'b1;
            end
        end
    endfunction

    // Every byte the escape decoder accepts is delivered, but the stream check
    // stops looking once the string has failed.
    function automatic void emit_byte(input logic [7:0] b);
        if (emit_cnt < MAX_BEATS) begin
            emit_buf[emit_cnt] = b;
            emit_cnt++;
        end
        if (!failed) check_utf8(b);
    endfunction

    function automatic void emit_code(input logic [20:0] cp);
        logic [3:0][7:0] b;
        int n;
        utf8_bytes(cp, b, n);
        for (int k = 0; k < n; k++) emit_byte(b[k]);
    endfunction

    // Advances the escape decoder by one byte.
    function automatic void take_char(input logic [7:0] c);
        int v;
        case (ph)
            PH_PLAIN: begin
                if (c == CH_BSLASH) ph = PH_ESCAPE;
                else if (c < CH_SPACE) failed = 1'b1;
                else emit_byte(c);
            end
            PH_ESCAPE: begin
                ph = PH_PLAIN;
                if (c == CH_QUOTE || c == CH_BSLASH) emit_byte(c);
                else if (c == CH_N) emit_byte(CH_LF);
                else if (c == CH_R) emit_byte(CH_CR);
                else if (c == CH_T) emit_byte(CH_TAB);
                else if (c == CH_U) begin
                    ph      = PH_HIGH_HEX;
                    digits  = '0;
                    hi_unit = '0;
                end else failed = 1'b1;
            end
            PH_HIGH_HEX: begin
                v = hex_nibble(c);
                if (v < 0) failed = 1'b1;
                else begin
                    hi_unit = {hi_unit[11:0], 4'(v)};
                    if (digits < 2'd3) digits = digits + 2'd1;
                    else begin
                        digits = '0;
                        if (hi_unit >= HIGH_SURR_LO && hi_unit <= HIGH_SURR_HI)
                            ph = PH_LOW_BSLASH;
                        else if (hi_unit >= LOW_SURR_LO && hi_unit <= LOW_SURR_HI)
                            failed = 1'b1;
                        else begin
                            ph = PH_PLAIN;
                            emit_code(21'(hi_unit));
                        end
                    end
                end
            end
            PH_LOW_BSLASH: begin
                if (c == CH_BSLASH) ph = PH_LOW_U;
                else failed = 1'b1;
            end
            PH_LOW_U: begin
                if (c == CH_U) begin
                    ph      = PH_LOW_HEX;
                    digits  = '0;
                    lo_unit = '0;
                end else failed = 1'b1;
            end
            PH_LOW_HEX: begin
                v = hex_nibble(c);
                if (v < 0) failed = 1'b1;
                else begin
                    lo_unit = {lo_unit[11:0], 4'(v)};
                    if (digits < 2'd3) digits = digits + 2'd1;
                    else begin
                        digits = '0;
                        if (lo_unit < LOW_SURR_LO || lo_unit > LOW_SURR_HI) failed = 1'b1;
                        else begin
                            ph = PH_PLAIN;
                            emit_code(21'h10000 + 21'({hi_unit - HIGH_SURR_LO, 10'b0})
                                      + 21'(lo_unit - LOW_SURR_LO));
                        end
                    end
                end
            end
            default: failed = 1'b1;
        endcase
    endfunction

    // Works out the result beats of one accepted input beat into pred_beats.
    function automatic void decode_item(input logic [7:0] c, input logic has,
                                        input logic last);
        logic ok;
        logic tail;
        emit_cnt = 0;
        if (has && !failed) take_char(c);
        pred_n = emit_cnt;
        ok = !failed && ph == PH_PLAIN && cont_owed == 2'd0;
        if (last && pred_n == 0) begin
            // A string that ends without a byte still gets one closing beat.
            pred_beats[0] = '{8'h00, 1'b0, 1'b1, 1'b1, ok};
            pred_n = 1;
        end else begin
            for (int k = 0; k < pred_n; k++) begin
                tail = (k == pred_n - 1);
                pred_beats[k] = '{emit_buf[k], 1'b1, tail, tail && last, tail && last && ok};
            end
        end
        if (last) clear_state();
    endfunction

    task automatic add_byte(input logic [7:0] b);
        str_q.push_back('{b, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0});
        // Now and then an empty, non-closing beat sits between bytes; the block
        // must let it pass without any effect.
        if ($urandom_range(0, 19) == 0)
            str_q.push_back('{8'($urandom), 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0});
    endtask

    // Four hex digits in random letter case; with spoil set, one of them is
    // replaced by a byte that is not a hex digit.
    task automatic add_hex(input logic [15:0] v, input bit spoil);
        int bad_pos;
        logic [3:0] nib;
        logic [7:0] c;
        bad_pos = spoil ? $urandom_range(0, 3) : -1;
        for (int i = 3; i >= 0; i--) begin
            nib = v[i*4 +: 4];
            if (i == bad_pos) begin
                do c = 8'($urandom); while (hex_nibble(c) >= 0);
            end else if (nib < 4'd10) begin
                c = 8'h30 + 8'(nib);
            end else begin
                c = ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(nib) - 8'd10;
            end
            add_byte(c);
        end
    endtask

    // Presents one input beat after an optional gap and waits for the handshake.
    // i_valid gets exactly one assignment per time step: either it drops for a
    // gap or it stays high with the next payload.
    task automatic send_beat(input t_row r, input bit calm);
        int gap;
        gap = calm ? 0 : idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_in_byte  <= r.in_byte;
        i_has_byte <= r.has_byte;
        i_last_in  <= r.last_in;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        // Accepted at this edge; the predictor moves on in the same step.
        decode_item(r.in_byte, r.has_byte, r.last_in);
        if (r.typed)
            due_beats.push_back('{r.exp_byte, r.exp_bvalid, 1'b1, 1'b1, r.exp_ok});
        else
            for (int k = 0; k < pred_n; k++) due_beats.push_back(pred_beats[k]);
    endtask

    // Receiver: runs of ready, mostly short with the odd long one, broken up by
    // stalls of random length.
    initial begin
        int run;
        int gap;
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
            i_ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            gap = idle_len();
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // Output checker: each accepted result beat is matched against the oldest
    // beat still owed.
    always @(posedge i_clk) begin : result_check
        t_beat got;
        t_beat want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_out_byte, o_byte_valid, o_run_last, o_string_done, o_string_ok};
            if (due_beats.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("%0t: result beat with nothing owed: byte=%h bv=%b rl=%b done=%b ok=%b",
                             $realtime, got.out_byte, got.byte_valid, got.run_last,
                             got.string_done, got.string_ok);
            end else begin
                want = due_beats.pop_front();
                if (got !== want) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: mismatch: expected byte=%h bv=%b rl=%b done=%b ok=%b,",
                                 $realtime, want.out_byte, want.byte_valid, want.run_last,
                                 want.string_done, want.string_ok,
                                 " got byte=%h bv=%b rl=%b done=%b ok=%b", got.out_byte,
                                 got.byte_valid, got.run_last, got.string_done, got.string_ok);
                end
            end
        end
    end

    // Stimulus: reset, the directed table, then random strings, then drain.
    initial begin
        int sent;
        int n_tok;
        int kind;
        int n;
        logic [20:0] cp;
        logic [15:0] hi;
        logic [15:0] lo;
        logic [3:0][7:0] ub;
        bit calm;

        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_in_byte  <= 8'h00;
        i_has_byte <= 1'b0;
        i_last_in  <= 1'b0;
        clear_state();

        // Directed rows. Where the closing beat is obvious it is written in
        // the row; the rest go through the predictor.
        dir_rows = '{
            // An empty beat that does not close the string: no effect at all.
            '{8'h00,     1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            // Empty string straight after reset passes.
            '{8'h00,     1'b0, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1},
            // A raw control byte fails and delivers nothing.
            '{8'h00,     1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0},
            // 0xFF is copied but cannot start a UTF-8 sequence.
            '{8'hFF,     1'b1, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b0},
            // Highest plain ASCII byte passes.
            '{8'h7F,     1'b1, 1'b1, 1'b1, 8'h7F, 1'b1, 1'b1},
            // Quote and tab escapes.
            '{CH_BSLASH, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{CH_QUOTE,  1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{CH_BSLASH, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{CH_T,      1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
            // Unknown escape letter.
            '{CH_BSLASH, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{8'h78,     1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0},
            // String that ends right after a backslash.
            '{CH_BSLASH, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0},
            // Surrogate pair for a four-byte code point, closing on the last digit.
            '{CH_BSLASH, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{CH_U,      1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{8'h44,     1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{8'h38,     1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{8'h33,     1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{8'h64,     1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{CH_BSLASH, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{CH_U,      1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{8'h44,     1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{8'h45,     1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{8'h30,     1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{8'h30,     1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) send_beat(dir_rows[i], 1'b0);

        // Random strings: mostly well-formed tokens with random content, plus a
        // share of noise and broken sequences.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            str_q.delete();
            n_tok = $urandom_range(0, 7);
            repeat (n_tok) begin
                kind = $urandom_range(0, 99);
                if (kind < 25) begin
                    // Plain printable byte.
                    do cp = 21'($urandom_range(8'h20, 8'h7F)); while (cp[7:0] == CH_BSLASH);
                    add_byte(cp[7:0]);
                end else if (kind < 40) begin
                    // One of the short escapes.
                    add_byte(CH_BSLASH);
                    case ($urandom_range(0, 4))
                        0:       add_byte(CH_QUOTE);
                        1:       add_byte(CH_BSLASH);
                        2:       add_byte(CH_N);
                        3:       add_byte(CH_R);
                        default: add_byte(CH_T);
                    endcase
                end else if (kind < 52) begin
                    // A \u escape outside the surrogate range, of every length.
                    case ($urandom_range(0, 2))
                        0: hi = 16'($urandom_range(0, 16'h7F));
                        1: hi = 16'($urandom_range(16'h80, 16'h7FF));
                        default: begin
                            do hi = 16'($urandom_range(16'h800, 16'hFFFF));
                            while (hi >= HIGH_SURR_LO && hi <= LOW_SURR_HI);
                        end
                    endcase
                    add_byte(CH_BSLASH);
                    add_byte(CH_U);
                    add_hex(hi, 1'b0);
                end else if (kind < 62) begin
                    // A proper surrogate pair.
                    hi = 16'($urandom_range(HIGH_SURR_LO, HIGH_SURR_HI));
                    lo = 16'($urandom_range(LOW_SURR_LO, LOW_SURR_HI));
                    add_byte(CH_BSLASH);
                    add_byte(CH_U);
                    add_hex(hi, 1'b0);
                    add_byte(CH_BSLASH);
                    add_byte(CH_U);
                    add_hex(lo, 1'b0);
                end else if (kind < 78) begin
                    // Raw multi-byte UTF-8 that is well formed.
                    case ($urandom_range(0, 2))
                        0: cp = 21'($urandom_range(21'h80, 21'h7FF));
                        1: begin
                            do cp = 21'($urandom_range(21'h800, 21'hFFFF));
                            while (cp >= 21'(HIGH_SURR_LO) && cp <= 21'(LOW_SURR_HI));
                        end
                        default: cp = 21'($urandom_range(21'h10000, CODE_MAX));
                    endcase
                    utf8_bytes(cp, ub, n);
                    for (int k = 0; k < n; k++) add_byte(ub[k]);
                end else if (kind < 82) begin
                    // Any byte at all.
                    add_byte(8'($urandom));
                end else if (kind < 85) begin
                    // Backslash followed by any byte.
                    add_byte(CH_BSLASH);
                    add_byte(8'($urandom));
                end else if (kind < 89) begin
                    // A \u escape with one digit that is not hex.
                    add_byte(CH_BSLASH);
                    add_byte(CH_U);
                    add_hex(16'($urandom), 1'b1);
                end else if (kind < 93) begin
                    // Surrogates used the wrong way.
                    hi = 16'($urandom_range(HIGH_SURR_LO, HIGH_SURR_HI));
                    add_byte(CH_BSLASH);
                    add_byte(CH_U);
                    case ($urandom_range(0, 3))
                        0: add_hex(16'($urandom_range(LOW_SURR_LO, LOW_SURR_HI)), 1'b0);
                        1: begin
                            add_hex(hi, 1'b0);
                            add_byte(8'($urandom_range(8'h20, 8'h7E)));
                        end
                        2: begin
                            add_hex(hi, 1'b0);
                            add_byte(CH_BSLASH);
                            add_byte(CH_N);
                        end
                        default: begin
                            add_hex(hi, 1'b0);
                            add_byte(CH_BSLASH);
                            add_byte(CH_U);
                            add_hex(16'($urandom_range(0, HIGH_SURR_HI)), 1'b0);
                        end
                    endcase
                end else begin
                    // Raw UTF-8 that the stream check must reject.
                    case ($urandom_range(0, 5))
                        0: begin
                            // Overlong two-byte form.
                            add_byte(8'hC0 | 8'($urandom_range(0, 1)));
                            add_byte(8'h80 | 8'($urandom_range(0, 8'h3F)));
                        end
                        1: begin
                            // Overlong four-byte form.
                            add_byte(8'hF0);
                            add_byte(8'h80 | 8'($urandom_range(0, 8'h0F)));
                            add_byte(8'h80 | 8'($urandom_range(0, 8'h3F)));
                            add_byte(8'h80 | 8'($urandom_range(0, 8'h3F)));
                        end
                        2: begin
                            // Beyond the last code point.
                            utf8_bytes(21'($urandom_range(21'h110000, 21'h1FFFFF)), ub, n);
                            for (int k = 0; k < n; k++) add_byte(ub[k]);
                        end
                        3: begin
                            // An encoded surrogate.
                            utf8_bytes(21'($urandom_range(HIGH_SURR_LO, LOW_SURR_HI)), ub, n);
                            for (int k = 0; k < n; k++) add_byte(ub[k]);
                        end
                        4: begin
                            // A sequence that lacks its final continuation byte.
                            utf8_bytes(21'($urandom_range(21'h80, CODE_MAX)), ub, n);
                            for (int k = 0; k < n - 1; k++) add_byte(ub[k]);
                        end
                        default: begin
                            // A stray continuation byte or an impossible lead byte.
                            if ($urandom_range(0, 1)) add_byte(8'($urandom_range(8'h80, 8'hBF)));
                            else add_byte(8'($urandom_range(8'hF8, 8'hFF)));
                        end
                    endcase
                end
            end

            // Sometimes the string is cut short in the middle of a token.
            if (str_q.size() > 0 && $urandom_range(0, 15) == 0)
                repeat ($urandom_range(1, 3)) if (str_q.size() > 0) void'(str_q.pop_back());

            // Close the string on its final byte, or with a separate empty beat.
            if (str_q.size() == 0 || $urandom_range(0, 4) == 0)
                str_q.push_back('{8'($urandom), 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0});
            else
                str_q[str_q.size() - 1].last_in = 1'b1;

            // Some strings go through with no gaps on the input side.
            calm = ($urandom_range(0, 4) == 0);
            foreach (str_q[i]) begin
                send_beat(str_q[i], calm);
                if (str_q[i].has_byte || str_q[i].last_in) sent++;
            end
        end
        i_valid <= 1'b0;

        // Let every owed beat arrive, then watch a little longer for strays.
        while (due_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0 && due_beats.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
